// ===== rtl/lstm_pkg.sv =====
// Package: shared constants, types and fixed-point helpers for the LSTM sample block.
`default_nettype none
package lstm_pkg;
  localparam int UNITS = 8;
  localparam int ROWS = 4 * UNITS;
  localparam int MEM_DEPTH = 512;
  localparam int AW = 9;
  localparam int UW = (UNITS > 1) ? $clog2(UNITS) : 1;
  localparam int RW = $clog2(ROWS);
  localparam int BASE_B = 4 * UNITS;
  localparam int BASE_WH = 8 * UNITS;
  localparam int BASE_LW = 8 * UNITS + 4 * UNITS * UNITS;
  localparam int BASE_LB = BASE_LW + UNITS;
  localparam int ACC_W = 48;
  localparam logic signed [15:0] ONE_Q12 = 16'sd4096;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_RSVD = 2'd3;

  // Control from the sequencer to every cell.
  typedef struct packed {
    logic clear;   // zero c and h
    logic shift;   // rotate the h ring by one cell
    logic load;    // take new c and h at the tail, rotate both rings
  } cell_ctl_t;

  function automatic logic signed [13:0] tanh_tab(input logic [4:0] i);
    logic signed [13:0] v;
    unique case (i)
      5'd0: v = 14'sd0;     5'd1: v = 14'sd1003;  5'd2: v = 14'sd1893;
      5'd3: v = 14'sd2602;  5'd4: v = 14'sd3119;  5'd5: v = 14'sd3475;
      5'd6: v = 14'sd3707;  5'd7: v = 14'sd3856;  5'd8: v = 14'sd3949;
      5'd9: v = 14'sd4006;  5'd10: v = 14'sd4041; 5'd11: v = 14'sd4062;
      5'd12: v = 14'sd4076; 5'd13: v = 14'sd4084; 5'd14: v = 14'sd4089;
      5'd15: v = 14'sd4091; 5'd16: v = 14'sd4093; 5'd17: v = 14'sd4094;
      5'd18: v = 14'sd4095; 5'd19: v = 14'sd4095; default: v = 14'sd4096;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] tanh_q12(input logic signed [15:0] x);
    logic [16:0] u;
    logic [6:0] idx;
    logic signed [13:0] d;
    logic signed [24:0] p;
    logic signed [13:0] y;
    u = x[15] ? 17'(-{x[15], x}) : {1'b0, x};
    idx = u[16:10];
    d = tanh_tab(5'(idx + 7'd1)) - tanh_tab(idx[4:0]);
    p = d * $signed({1'b0, u[9:0]}) + 25'sd512;
    if (idx >= 7'd20) y = 14'sd4096;
    else y = tanh_tab(idx[4:0]) + 14'(p >>> 10);
    return x[15] ? 16'(-y) : 16'(y);
  endfunction

  function automatic logic signed [15:0] sigmoid_q12(input logic signed [15:0] x);
    logic signed [16:0] t;
    t = 17'(ONE_Q12) + 17'(tanh_q12(x >>> 1));
    return 16'(t >>> 1);
  endfunction

  function automatic logic signed [15:0] round_sat(input logic signed [ACC_W-1:0] v,
                                                   input logic [4:0] s);
    logic signed [ACC_W-1:0] r;
    r = (v + (ACC_W'(1) <<< (s - 5'd1))) >>> s;
    if (r > 48'sd32767) return 16'sh7fff;
    if (r < -48'sd32768) return 16'sh8000;
    return r[15:0];
  endfunction
endpackage
`default_nettype wire

// ===== rtl/lstm_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`default_nettype none
module lstm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/lstm_cell.sv =====
// One state cell: holds c and h for one unit, hands them to its neighbour.
`default_nettype none
module lstm_cell (
  input  wire logic                   clk,
  input  wire lstm_pkg::cell_ctl_t    ctl,
  input  wire logic signed [15:0]     c_in,
  input  wire logic signed [15:0]     h_in,
  output logic signed [15:0]          c,
  output logic signed [15:0]          h
);
  import lstm_pkg::*;
  // c and h reset through the clear strobe, which the sequencer raises at reset
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      c <= '0;
      h <= '0;
    end else if (ctl.load) begin
      c <= c_in;
      h <= h_in;
    end else if (ctl.shift) begin
      h <= h_in;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/lstm_residual_sample_model_top.sv =====
// Top level: LSTM sample block with weight RAM, MAC sequencer and a ring of state cells.
// Usage:
//  s_axis carries one beat per item: tuser = kind (0 sample, 1 weight write, 2 clear,
//  3 ignored); tdata = {weight_value, weight_address, sample_in}, sample lowest.
//  m_axis returns one beat per sample item: tdata = sample_out (Q1.15).
//  Weight writes, clears and ignored kinds give no beat.
//  A sample item runs one multiply-accumulate per cycle from the weight RAM:
//  each of the 4*UNITS gate rows steps through bias, input weight, one hidden
//  weight per cell and a drain, the hidden values rotating through the cell
//  ring so the head cell always feeds the MAC. Then each cell is updated in
//  turn (gate activations, products, tanh of the new c, load into the ring),
//  and the linear readout follows. The single MAC and the RAM read port set
//  the length of this work. Reset (rst, synchronous) zeroes c and h and the
//  control; the weight RAM is cleared by a pass over all MEM_DEPTH words after
//  reset during which s_axis_tready stays low. A stalled receiver holds the
//  result in the output register; the next item is not taken until that beat
//  leaves.
`default_nettype none
module lstm_residual_sample_model_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // sample_in[15:0], weight_address[24:16],
                                          // weight_value[40:25], zero fill
  input  wire logic [1:0]  s_axis_tuser,  // kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata   // sample_out
);
  import lstm_pkg::*;

  localparam logic [2:0] ST_WIPE = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_GATE = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_LIN  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]  state;
  logic [AW:0] wipe;
  logic [RW:0] row;       // gate row, or cell index in update phase
  logic [UW+2:0] step;    // step within a row
  logic signed [15:0] x;
  logic signed [ACC_W-1:0] acc;
  logic signed [15:0] zr [ROWS];
  logic signed [15:0] out_q;

  // weight RAM
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata, rdata;
  logic [AW+6:0] ra_full;
  logic          ra_ok, ra_ok_q;
  lstm_ram #(.WIDTH(16), .DEPTH(MEM_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // cell ring
  cell_ctl_t ctl;
  cell_ctl_t ctl_next;
  logic signed [15:0] cq [UNITS];
  logic signed [15:0] hq [UNITS];
  logic signed [15:0] c_new, h_new;
  for (genvar g = 0; g < UNITS; g++) begin : g_cell
    logic signed [15:0] ci, hi;
    if (g == UNITS - 1) begin : g_tail
      assign ci = ctl.load ? c_new : cq[0];
      assign hi = ctl.load ? h_new : hq[0];
    end else begin : g_mid
      assign ci = cq[g+1];
      assign hi = hq[g+1];
    end
    lstm_cell u_cell (.clk(clk), .ctl(ctl), .c_in(ci), .h_in(hi), .c(cq[g]), .h(hq[g]));
  end

  logic accept;
  assign s_axis_tready = (state == ST_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata = out_q;

  // read address per step: gate 0 bias, 1 input, 2..U+1 hidden; readout 0 bias, 1..U
  always_comb begin
    ra_full = '0;
    if (state == ST_GATE) begin
      if (step == '0) ra_full = (AW+7)'(BASE_B) + (AW+7)'(row);
      else if (step == (UW+3)'(1)) ra_full = (AW+7)'(row);
      else ra_full = (AW+7)'(BASE_WH) + (AW+7)'(step - (UW+3)'(2)) * (AW+7)'(ROWS)
                     + (AW+7)'(row);
    end else begin
      if (step == '0) ra_full = (AW+7)'(BASE_LB);
      else ra_full = (AW+7)'(BASE_LW) + (AW+7)'(step - (UW+3)'(1));
    end
    ra_ok = ra_full < (AW+7)'(MEM_DEPTH);
    raddr = ra_full[AW-1:0];
  end

  assign we = (state == ST_WIPE) || (accept && s_axis_tuser == KIND_WRITE);
  assign waddr = (state == ST_WIPE) ? wipe[AW-1:0] : s_axis_tdata[24:16];
  assign wdata = (state == ST_WIPE) ? 16'd0 : s_axis_tdata[40:25];

  // MAC operand: weight from previous cycle's read against the matching factor
  logic signed [15:0] w;
  logic [UW+2:0] pstep;
  logic signed [ACC_W-1:0] prod;
  assign w = ra_ok_q ? $signed(rdata) : 16'sd0;
  always_comb begin
    prod = '0;
    if (state == ST_GATE) begin
      if (pstep == '0) prod = ACC_W'(w) <<< 15;
      else if (pstep == (UW+3)'(1)) prod = ACC_W'(x * w);
      else prod = ACC_W'(hq[0] * w) <<< 3;
    end else begin
      if (pstep == '0) prod = ACC_W'(w) <<< 12;
      else prod = ACC_W'(hq[0] * w);
    end
  end

  // cell update pipeline on head cell values (zr index by row)
  logic [1:0] us;
  logic signed [15:0] gi, gf, gg, go, tc;
  logic signed [31:0] p1, p2;
  always_comb begin
    c_new = round_sat(ACC_W'(p1) + ACC_W'(p2), 5'd12);
    h_new = round_sat(ACC_W'(go * tc), 5'd12);
  end

  // Cell strobes, registered: clear at reset and on a clear beat, shift while the
  // MAC walks the hidden values, load once the head cell's update is ready.
  always_comb begin
    ctl_next = '0;
    if (rst) begin
      ctl_next.clear = 1'b1;
    end else begin
      if (accept && s_axis_tuser == KIND_CLEAR) ctl_next.clear = 1'b1;
      if (state == ST_GATE && step >= (UW+3)'(2) && step <= (UW+3)'(UNITS + 1))
        ctl_next.shift = 1'b1;
      if (state == ST_LIN && step >= (UW+3)'(1) && step <= (UW+3)'(UNITS))
        ctl_next.shift = 1'b1;
      if (state == ST_UPD && us == 2'd3) ctl_next.load = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    ctl <= ctl_next;
    ra_ok_q <= ra_ok;
    pstep <= step;
    if (rst) begin
      state <= ST_WIPE;
      wipe <= '0;
      step <= '0;
      row <= '0;
      us <= '0;
    end else begin
      unique case (state)
        ST_WIPE: begin
          wipe <= wipe + 1'b1;
          if (wipe == (AW+1)'(MEM_DEPTH - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            x <= s_axis_tdata[15:0];
            row <= '0;
            step <= '0;
            acc <= '0;
            if (s_axis_tuser == KIND_SAMPLE) state <= ST_GATE;
          end
        end
        ST_GATE: begin
          // step 0..U+1 issue reads; the MAC works on the read data of the previous step
          if (step == (UW+3)'(UNITS + 2)) begin
            zr[row[RW-1:0]] <= round_sat(acc + prod, 5'd15);
            acc <= '0;
            step <= '0;
            if (row == (RW+1)'(ROWS - 1)) begin
              state <= ST_UPD;
              row <= '0;
              us <= '0;
            end else row <= row + 1'b1;
          end else begin
            if (step != '0) acc <= acc + prod;
            step <= step + 1'b1;
          end
        end
        ST_UPD: begin
          us <= us + 1'b1;
          unique case (us)
            2'd0: begin
              gi <= sigmoid_q12(zr[row[RW-1:0]]);
              gf <= sigmoid_q12(zr[RW'(row + (RW+1)'(UNITS))]);
              gg <= tanh_q12(zr[RW'(row + (RW+1)'(2 * UNITS))]);
              go <= sigmoid_q12(zr[RW'(row + (RW+1)'(3 * UNITS))]);
            end
            2'd1: begin
              p1 <= gf * cq[0];
              p2 <= gi * gg;
            end
            2'd2: tc <= tanh_q12(c_new);
            default: begin
              if (row == (RW+1)'(UNITS - 1)) begin
                state <= ST_LIN;
                step <= '0;
                acc <= ACC_W'(x) <<< 9;
              end
              row <= row + 1'b1;
            end
          endcase
        end
        ST_LIN: begin
          if (step != '0) acc <= acc + prod;
          if (step == (UW+3)'(UNITS + 1)) begin
            out_q <= round_sat(acc + prod, 5'd9);
            state <= ST_OUT;
          end else step <= step + 1'b1;
        end
        ST_OUT: begin
          if (m_axis_tready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/lstm_checker.sv =====
// Port-level checker for the LSTM sample block, bound to the top level.
`default_nettype none
module lstm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);
  import lstm_pkg::*;
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed while stalled");
  a_one: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while a result waits");
  a_nores: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser != KIND_SAMPLE |=> !m_axis_tvalid)
    else $error("result after a non-sample item");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_SAMPLE |=> !s_axis_tready)
    else $error("new item accepted during sample work");
endmodule

bind lstm_residual_sample_model_top lstm_checker u_chk (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .s_axis_tuser(s_axis_tuser), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
